[hdl/lrb_pkg.sv]
// Shared types, constants and helper functions for the line-assembling receive buffer.
// Used by lrb_char_store, lrb_line_queue and line_assembling_receive_buffer.
`timescale 1ns / 1ps

package lrb_pkg;

  localparam int BUF_DEPTH        = 64;
  localparam int LINE_QUEUE_DEPTH = 16;

  localparam int BIDX_W = $clog2(BUF_DEPTH);
  localparam int QPTR_W = (LINE_QUEUE_DEPTH > 1) ? $clog2(LINE_QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(LINE_QUEUE_DEPTH + 1);

  typedef logic [7:0]        byte_t;
  typedef logic [BIDX_W-1:0] bidx_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  // Escape byte and the letters that turn it into a control code.
  localparam byte_t ESC_MARK = 8'h5b;
  localparam byte_t CHR_A    = 8'd65;
  localparam byte_t CHR_D    = 8'd68;

  localparam logic FUNC_RX   = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PMIN = 1'd1;

  localparam byte_t TERM_RESET = 8'd13;
  localparam byte_t PMIN_RESET = 8'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RX_EVAL,
    ST_RD_HEAD,
    ST_RD_BYTES
  } lrb_state_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lq_status_t;

  // Next ring position.
  function automatic bidx_t bidx_inc(input bidx_t i);
    return (i == bidx_t'(BUF_DEPTH - 1)) ? '0 : bidx_t'(i + 1'b1);
  endfunction

  // Number of ring positions from start up to (not including) stop.
  function automatic bidx_t bidx_dist(input bidx_t stop, input bidx_t start);
    logic [BIDX_W:0] t;
    if (stop >= start) begin
      t = {1'b0, stop} - {1'b0, start};
    end else begin
      t = {1'b0, stop} + (BIDX_W + 1)'(BUF_DEPTH) - {1'b0, start};
    end
    return t[BIDX_W-1:0];
  endfunction

endpackage

[hdl/lrb_char_store.sv]
// Byte ring store: one write port, one registered read port, per-entry valid bits.
// Depends on lrb_pkg.
`timescale 1ns / 1ps

module lrb_char_store
  import lrb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  bidx_t wr_addr,
  input  byte_t wr_data,
  input  bidx_t rd_addr,
  output byte_t rd_data
);

  byte_t                mem [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] vld_r;
  byte_t                rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Entries never written read as zero, matching the cleared state after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[hdl/lrb_line_queue.sv]
// FIFO of line-end positions held in a small synchronous memory.
// Depends on lrb_pkg. The head entry is read every cycle into a register.
`timescale 1ns / 1ps

module lrb_line_queue
  import lrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bidx_t      push_pos,
  input  logic       pop,
  output bidx_t      head_pos,
  output lq_status_t status
);

  bidx_t mem [LINE_QUEUE_DEPTH];
  qptr_t head_r, head_nxt;
  qptr_t tail_r, tail_nxt;
  qcnt_t cnt_r, cnt_nxt;
  bidx_t head_pos_r;
  logic  push_ok;
  logic  pop_ok;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == qcnt_t'(LINE_QUEUE_DEPTH));

  // A marker that arrives while the queue is full is dropped.
  assign push_ok = push && !status.full;
  assign pop_ok  = pop && !status.empty;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      tail_nxt = (tail_r == qptr_t'(LINE_QUEUE_DEPTH - 1)) ? '0 : qptr_t'(tail_r + 1'b1);
    end
    if (pop_ok) begin
      head_nxt = (head_r == qptr_t'(LINE_QUEUE_DEPTH - 1)) ? '0 : qptr_t'(head_r + 1'b1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = qcnt_t'(cnt_r + 1'b1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = qcnt_t'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= push_pos;
    end
    head_pos_r <= mem[head_r];
  end

  assign head_pos = head_pos_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= qcnt_t'(LINE_QUEUE_DEPTH))
    else $error("line queue count exceeds its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("line queue popped while empty");

endmodule

[hdl/line_assembling_receive_buffer.sv]
// Top level of the line-assembling receive buffer: command interface, config registers,
// control sequencer. Depends on lrb_pkg, lrb_char_store and lrb_line_queue.
// A receive transaction keeps busy high for one cycle after acceptance and gives no result.
// A read transaction of a line of n bytes keeps busy high through its head state and read-out;
// each byte passes the registered store read and the result register, one byte per cycle. An
// empty queue or an empty line gives its single result. The receiver cannot stall the results.
// Synchronous active-low reset clears all control state and the store's valid bits at once.
`timescale 1ns / 1ps

module line_assembling_receive_buffer
  import lrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Command channel.
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [7:0]           in_rx_byte,
  // Result channel.
  output logic                 out_strobe,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_line_last,
  output logic                 out_no_line,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  lrb_state_t state_r, state_nxt;
  logic       accept;

  byte_t term_r;
  byte_t pmin_r;

  byte_t sym_r, sym_nxt;
  bidx_t wr_idx_r, wr_idx_nxt;
  bidx_t prev_wr_r, prev_wr_nxt;
  bidx_t rd_idx_r, rd_idx_nxt;
  bidx_t cur_r, cur_nxt;
  bidx_t rem_r, rem_nxt;

  logic  char_wr_en;
  bidx_t char_wr_addr;
  byte_t char_wr_data;
  bidx_t char_rd_addr;
  byte_t char_rd_data;

  logic       q_push;
  logic       q_pop;
  bidx_t      q_head_pos;
  lq_status_t q_status;
  bidx_t      line_len;

  logic  strobe_r, strobe_nxt;
  byte_t byte_r, byte_nxt;
  logic  valid_r, valid_nxt;
  logic  last_r, last_nxt;
  logic  none_r, none_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Configuration registers are always writable; the environment must write them only while
  // the block is idle. The block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r <= TERM_RESET;
      pmin_r <= PMIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TERM: term_r <= cfg_data;
        CFG_PMIN: pmin_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lrb_char_store u_char_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (char_wr_en),
    .wr_addr (char_wr_addr),
    .wr_data (char_wr_data),
    .rd_addr (char_rd_addr),
    .rd_data (char_rd_data)
  );

  lrb_line_queue u_line_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pos (wr_idx_r),
    .pop      (q_pop),
    .head_pos (q_head_pos),
    .status   (q_status)
  );

  // Length of the oldest queued line, measured from the current read position.
  assign line_len = bidx_dist(q_head_pos, rd_idx_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_func == FUNC_READ) ? ST_RD_HEAD : ST_RX_EVAL;
        end
      end
      ST_RX_EVAL: begin
        state_nxt = ST_IDLE;
      end
      ST_RD_HEAD: begin
        if (q_status.empty || line_len == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RD_BYTES;
        end
      end
      ST_RD_BYTES: begin
        if (rem_r == bidx_t'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control. The store is read in the cycle before the data is used:
  // in idle the byte at the last stored position is fetched for the escape check, and during
  // read-out the fetch runs one position ahead of the byte being sent.
  always_comb begin
    sym_nxt      = sym_r;
    wr_idx_nxt   = wr_idx_r;
    prev_wr_nxt  = prev_wr_r;
    rd_idx_nxt   = rd_idx_r;
    cur_nxt      = cur_r;
    rem_nxt      = rem_r;
    char_wr_en   = 1'b0;
    char_wr_addr = wr_idx_r;
    char_wr_data = sym_r;
    char_rd_addr = prev_wr_r;
    q_push       = 1'b0;
    q_pop        = 1'b0;
    strobe_nxt   = 1'b0;
    byte_nxt     = '0;
    valid_nxt    = 1'b0;
    last_nxt     = 1'b0;
    none_nxt     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sym_nxt = in_rx_byte;
        end
      end
      ST_RX_EVAL: begin
        // The terminator check wins over the escape rule.
        if (sym_r == term_r) begin
          q_push = 1'b1;
        end else if (char_rd_data == ESC_MARK && (sym_r inside {[CHR_A:CHR_D]})) begin
          char_wr_en   = 1'b1;
          char_wr_addr = prev_wr_r;
          char_wr_data = sym_r - CHR_A;
          q_push       = 1'b1;
        end else if (sym_r >= pmin_r) begin
          char_wr_en  = 1'b1;
          prev_wr_nxt = wr_idx_r;
          wr_idx_nxt  = bidx_inc(wr_idx_r);
        end
      end
      ST_RD_HEAD: begin
        char_rd_addr = rd_idx_r;
        if (q_status.empty) begin
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          none_nxt   = 1'b1;
        end else begin
          q_pop      = 1'b1;
          rd_idx_nxt = q_head_pos;
          cur_nxt    = bidx_inc(rd_idx_r);
          rem_nxt    = line_len;
          if (line_len == '0) begin
            strobe_nxt = 1'b1;
            last_nxt   = 1'b1;
          end
        end
      end
      ST_RD_BYTES: begin
        char_rd_addr = cur_r;
        cur_nxt      = bidx_inc(cur_r);
        rem_nxt      = rem_r - 1'b1;
        strobe_nxt   = 1'b1;
        valid_nxt    = 1'b1;
        byte_nxt     = char_rd_data;
        last_nxt     = (rem_r == bidx_t'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wr_idx_r  <= '0;
      prev_wr_r <= '0;
      rd_idx_r  <= '0;
      cur_r     <= '0;
      rem_r     <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_idx_r  <= wr_idx_nxt;
      prev_wr_r <= prev_wr_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cur_r     <= cur_nxt;
      rem_r     <= rem_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // Result payload registers and the latched receive byte.
  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    byte_r  <= byte_nxt;
    valid_r <= valid_nxt;
    last_r  <= last_nxt;
    none_r  <= none_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = valid_r;
  assign out_line_last  = last_r;
  assign out_no_line    = none_r;

  a_no_line_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_no_line) |-> (out_line_last && !out_byte_valid))
    else $error("no-line result is not a lone final result");

  a_readout_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_BYTES) |-> (rem_r != '0))
    else $error("read-out running with no bytes left");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

[tb/sv/lrb_tb_pkg.sv]
// Scoreboard for the line-assembling receive buffer testbench: a cycle-free predictor of
// the ring store and line-end queue plus the store of expected read-out bytes.
// Depends on lrb_pkg for widths, depths, codes and register indexes.
`timescale 1ns / 1ps

package lrb_tb_pkg;

  import lrb_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  valid;
    logic  last;
    logic  no_line;
  } line_result_t;

  class line_buffer_scoreboard;

    byte_t        ring [BUF_DEPTH];
    bidx_t        wr_pos;
    bidx_t        last_wr_pos;
    bidx_t        rd_pos;
    bidx_t        line_ends [LINE_QUEUE_DEPTH];
    qptr_t        le_head;
    qptr_t        le_tail;
    int           le_count;
    byte_t        term_char;
    byte_t        min_printable;
    line_result_t line_bytes_q [$];
    int           errors;
    int           items_noted;

    function new();
      foreach (ring[i]) ring[i] = '0;
      foreach (line_ends[i]) line_ends[i] = '0;
      wr_pos          = '0;
      last_wr_pos     = '0;
      rd_pos          = '0;
      le_head         = '0;
      le_tail         = '0;
      le_count        = 0;
      term_char       = TERM_RESET;
      min_printable   = PMIN_RESET;
      errors          = 0;
      items_noted     = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
      case (idx)
        CFG_TERM: term_char = val;
        CFG_PMIN: min_printable = val;
        default: ;
      endcase
    endfunction

    // Returns 1 when the line end was queued, 0 when the queue was full.
    function bit queue_line_end();
      if (le_count == LINE_QUEUE_DEPTH) return 1'b0;
      line_ends[le_tail] = wr_pos;
      le_tail = (le_tail == qptr_t'(LINE_QUEUE_DEPTH - 1)) ? '0 : qptr_t'(le_tail + 1'b1);
      le_count++;
      return 1'b1;
    endfunction

    function void note_input(input logic func, input byte_t rx);
      line_result_t r;
      bidx_t        line_end;
      int           len;
      if (func == FUNC_RX) begin
        // The terminator wins over the escape rule.
        if (rx == term_char) begin
          void'(queue_line_end());
        end else if (ring[last_wr_pos] == ESC_MARK && rx >= CHR_A && rx <= CHR_D) begin
          ring[last_wr_pos] = byte_t'(rx - CHR_A);
          void'(queue_line_end());
        end else if (rx >= min_printable) begin
          last_wr_pos  = wr_pos;
          ring[wr_pos] = rx;
          wr_pos = (wr_pos == bidx_t'(BUF_DEPTH - 1)) ? '0 : bidx_t'(wr_pos + 1'b1);
        end
      end else if (le_count == 0) begin
        r = '{data: '0, valid: 1'b0, last: 1'b1, no_line: 1'b1};
        line_bytes_q.push_back(r);
      end else begin
        line_end = line_ends[le_head];
        le_head  = (le_head == qptr_t'(LINE_QUEUE_DEPTH - 1)) ? '0 : qptr_t'(le_head + 1'b1);
        le_count--;
        len = (int'(line_end) + BUF_DEPTH - int'(rd_pos)) % BUF_DEPTH;
        if (len == 0) begin
          r = '{data: '0, valid: 1'b0, last: 1'b1, no_line: 1'b0};
          line_bytes_q.push_back(r);
        end
        for (int i = 0; i < len; i++) begin
          r = '{data: ring[(int'(rd_pos) + i) % BUF_DEPTH], valid: 1'b1,
                last: (i == len - 1), no_line: 1'b0};
          line_bytes_q.push_back(r);
        end
        rd_pos = line_end;
      end
      items_noted++;
    endfunction

    function void check_result(input byte_t data, input logic valid, input logic last,
                               input logic no_line);
      line_result_t want;
      if (line_bytes_q.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected result data=%02h valid=%0b last=%0b no_line=%0b",
                   $time, data, valid, last, no_line);
        errors++;
        return;
      end
      want = line_bytes_q.pop_front();
      if (want.data !== data || want.valid !== valid || want.last !== last ||
          want.no_line !== no_line) begin
        if (errors < 10)
          $display({"%0t: mismatch, expected data=%02h valid=%0b last=%0b no_line=%0b,",
                    " got data=%02h valid=%0b last=%0b no_line=%0b"},
                   $time, want.data, want.valid, want.last, want.no_line,
                   data, valid, last, no_line);
        errors++;
      end
    endfunction

  endclass

endpackage

[tb/sv/tb_line_assembling_receive_buffer.sv]
// Self-checking testbench for line_assembling_receive_buffer: directed corner cases, then
// six register settings with random line traffic, all checked against a scoreboard.
// Depends on lrb_pkg, lrb_tb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_line_assembling_receive_buffer
  import lrb_pkg::*, lrb_tb_pkg::*;
;

  // This limit leaves a wide margin over a clean run, even with the longest reads.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 75;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  logic                 in_func    = FUNC_RX;
  logic [7:0]           in_rx_byte = '0;
  logic                 out_strobe;
  logic [7:0]           out_byte;
  logic                 out_byte_valid;
  logic                 out_line_last;
  logic                 out_no_line;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_TERM;
  logic [7:0]           cfg_data   = '0;

  int unsigned           cycle_count = 0;
  int                    burst_left  = 0;
  line_buffer_scoreboard sb = new();

  // Directed opening: each entry is {func, rx_byte}. It walks through an empty queue, an
  // empty line, the bytes just below and at the printable threshold, every escape letter,
  // a terminator right after the escape byte, an escape letter after such a terminator
  // (the escape rule still sees the old byte), a letter just past the escape range, and
  // finally drains every queued line plus one read too many.
  logic [8:0] warmup [26] = '{
    {FUNC_READ, 8'h00},
    {FUNC_RX,   TERM_RESET},
    {FUNC_READ, 8'hff},
    {FUNC_RX,   8'h00},
    {FUNC_RX,   PMIN_RESET - 8'd1},
    {FUNC_RX,   PMIN_RESET},
    {FUNC_RX,   8'hff},
    {FUNC_RX,   ESC_MARK},
    {FUNC_RX,   CHR_A},
    {FUNC_RX,   ESC_MARK},
    {FUNC_RX,   TERM_RESET},
    {FUNC_RX,   CHR_A + 8'd1},
    {FUNC_RX,   ESC_MARK},
    {FUNC_RX,   CHR_A + 8'd2},
    {FUNC_RX,   ESC_MARK},
    {FUNC_RX,   CHR_D},
    {FUNC_RX,   ESC_MARK},
    {FUNC_RX,   CHR_D + 8'd1},
    {FUNC_RX,   TERM_RESET},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00}
  };

  line_assembling_receive_buffer i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_rx_byte    (in_rx_byte),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_line_last (out_line_last),
    .out_no_line   (out_no_line),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor. Outputs are read in the active region of the edge, so they still hold
  // the values of the cycle that this edge ends; each strobe marks one result.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_byte, out_byte_valid, out_line_last, out_no_line);
  end

  // Presents one command transaction and holds it until the block takes it. The sender
  // works in bursts: once a burst is used up, start drops for a random gap. Within a burst
  // start stays high across back-to-back transactions, so it is never lowered and raised
  // in the same time step.
  task automatic drive_item(input logic func, input byte_t rx);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      // Now and then a long burst, so that stretches without any idling occur too.
      burst_left = ($urandom_range(7, 0) == 0) ? 64 : $urandom_range(24, 1);
    end
    burst_left--;
    start      <= 1'b1;
    in_func    <= func;
    in_rx_byte <= rx;
    do @(posedge clk); while (busy);
    sb.note_input(func, rx);
  endtask

  // Lets the block drain: all expected bytes are back and busy is low. The few extra
  // cycles cover a receive transaction that is still being evaluated with no result.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.line_bytes_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers as two back-to-back transactions; valid stays high in between.
  task automatic set_regs(input byte_t term, input byte_t pmin);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TERM;
    cfg_data  <= term;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_TERM, term);
    cfg_index <= CFG_PMIN;
    cfg_data  <= pmin;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_PMIN, pmin);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t random_printable();
    return byte_t'($urandom_range(255, sb.min_printable));
  endfunction

  // Random line traffic. Most transactions build lines: printable bytes, terminators and
  // escape pairs; a few are raw noise, escape bytes followed by a letter near the escape
  // range, or long runs that produce maximum-length lines and wrap the ring over unread
  // data. read_pct sets how often a line is read back; a low value fills the line-end
  // queue so that later line ends are dropped.
  task automatic run_phase(input int read_pct);
    int target;
    int pick;
    target = sb.items_noted + PHASE_ITEMS;
    while (sb.items_noted < target) begin
      pick = $urandom_range(99, 0);
      if (pick < read_pct) begin
        drive_item(FUNC_READ, byte_t'($urandom));
      end else if (pick < read_pct + 12) begin
        drive_item(FUNC_RX, sb.term_char);
      end else if (pick < read_pct + 20) begin
        drive_item(FUNC_RX, ESC_MARK);
        drive_item(FUNC_RX, byte_t'($urandom_range(CHR_D + 1, CHR_A - 1)));
      end else if (pick < read_pct + 27) begin
        drive_item(FUNC_RX, byte_t'($urandom));
      end else if (pick < read_pct + 29) begin
        repeat ($urandom_range(70, 30)) drive_item(FUNC_RX, random_printable());
      end else begin
        drive_item(FUNC_RX, random_printable());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs with the reset values of both registers.
    foreach (warmup[i]) drive_item(warmup[i][8], warmup[i][7:0]);

    // Register settings go from typical to both extremes. The flood phase nearly never
    // reads, and the terminator of the last fixed setting is an escape letter, so the
    // terminator check has to win over the escape rule.
    wait_idle();
    set_regs(8'd10, 8'd32);
    run_phase(30);
    wait_idle();
    set_regs(TERM_RESET, 8'd0);
    run_phase(4);
    wait_idle();
    set_regs(8'd0, 8'd127);
    run_phase(25);
    wait_idle();
    set_regs(8'd255, 8'd255);
    run_phase(20);
    wait_idle();
    set_regs(CHR_A, 8'd1);
    run_phase(20);
    wait_idle();
    set_regs(byte_t'($urandom), byte_t'($urandom_range(ESC_MARK, 0)));
    run_phase(15);

    // Drain, then give any stray strobe time to show up before the verdict.
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.line_bytes_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
